>>> design/pwmcalc_pkg.sv
// ----------------------------------------------------------------------------
// pwmcalc_pkg
// Shared types and constants of the PWM period and duty calculator: stream
// layout, command and register codes, sequencer states and channel entry.
// ----------------------------------------------------------------------------
package pwmcalc_pkg;

    // default parameter values
    localparam int DEF_CLOCK_HZ     = 24000000;
    localparam int DEF_NUM_CHANNELS = 8;

    // field widths
    localparam int CMD_W   = 2;
    localparam int CHAN_W  = 3;
    localparam int VALUE_W = 16;
    localparam int CNT_W   = 16;

    // stream and configuration layout
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // clamp limits and rounding constants
    localparam logic [CNT_W-1:0] LIM_NARROW = 16'h00FF;
    localparam logic [CNT_W-1:0] LIM_WIDE   = 16'hFFFF;
    localparam logic [31:0]      DUTY_HALF  = 32'd32767;
    localparam logic [16:0]      DUTY_DIV   = 17'd65535;

    // reset values of the configuration registers
    localparam logic [7:0] RST_ENABLE   = 8'hAA;
    localparam logic [7:0] RST_POLARITY = 8'hFF;
    localparam logic [7:0] RST_CLKSEL   = 8'h00;
    localparam logic [2:0] RST_PRESCALE = 3'd0;
    localparam logic [7:0] RST_SCALE    = 8'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 2'd0,
        CMD_FREQ  = 2'd1,
        CMD_RATIO = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE_MASK   = 3'd0,
        REG_POLARITY_MASK = 3'd1,
        REG_CLKSEL_MASK   = 3'd2,
        REG_PRESCALE_A    = 3'd3,
        REG_PRESCALE_B    = 3'd4,
        REG_SCALE_A       = 3'd5,
        REG_SCALE_B       = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PRE,
        S_CLK,
        S_FREQ,
        S_FDIV,
        S_MUL,
        S_DUTY,
        S_QRY,
        S_QDIV,
        S_WB,
        S_OUT
    } state_t;

    // one channel's stored state
    typedef struct packed {
        logic [CNT_W-1:0] prescaler;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] ratio;
        logic             wide;
        logic [CNT_W-1:0] duty;
    } chan_entry_t;

endpackage

>>> design/pwm_channel_period_duty_calculator_core.sv
// ----------------------------------------------------------------------------
// pwm_channel_period_duty_calculator_core
// Per-channel PWM setting engine: prescaler and mode setup, period from
// frequency, rounded duty from ratio, and frequency and ratio readback.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                   | payload
//  --------+-----+-----------------------------+---------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready | tuser command, tdata chan/value
//  m_axis  | out | m_axis_tvalid/m_axis_tready | tuser flags, tdata result fields
//  cfg     | in  | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
//  The shared divider, two quotient bits per cycle, is run up to three
//  times per item. Channel state sits in one RAM; per-entry valid bits
//  make untouched entries read as zero after reset, so no clearing pass
//  is needed. A finished beat waits in the output register while the
//  next item is accepted; the sequencer stalls in its last state only if
//  that register is still full.
// ----------------------------------------------------------------------------
module pwm_channel_period_duty_calculator_core #(
    parameter int CLOCK_HZ     = pwmcalc_pkg::DEF_CLOCK_HZ,
    parameter int NUM_CHANNELS = pwmcalc_pkg::DEF_NUM_CHANNELS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] channel, [18:3] value
    input  logic [pwmcalc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] command
    input  logic [pwmcalc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [2:0] reg_index, [18:3] period_value, [34:19] duty_value,
    // [35] port_level, [36] hires_flag, [52:37] frequency_read,
    // [68:53] ratio_read
    output logic [pwmcalc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] wide_write, [1] registers_written
    output logic [pwmcalc_pkg::OUT_USER_W-1:0] m_axis_tuser,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pwmcalc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwmcalc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CLK_W   = $clog2(CLOCK_HZ + 1);
    localparam int DW      = CLK_W + (CLK_W % 2);
    localparam int CW      = (DW > 16) ? DW : 16;
    localparam int ADDR_W  = $clog2(NUM_CHANNELS);
    localparam int ENTRY_W = $bits(pwmcalc_pkg::chan_entry_t);

    // configuration registers
    logic [7:0] enable_reg;
    logic [7:0] polarity_reg;
    logic [7:0] clksel_reg;
    logic [2:0] prescale_a_reg;
    logic [2:0] prescale_b_reg;
    logic [7:0] scale_a_reg;
    logic [7:0] scale_b_reg;

    // sequencer
    pwmcalc_pkg::state_t state_reg;
    pwmcalc_pkg::state_t state_next;

    // item and working registers
    pwmcalc_pkg::cmd_t cmd_reg;
    logic [2:0]        ch_reg;
    logic [15:0]       val_reg;
    logic              oob_reg;
    logic [15:0]       pres_reg;
    logic [15:0]       period_reg;
    logic [15:0]       ratio_reg;
    logic              wide_reg;
    logic [15:0]       duty_reg;
    logic [CLK_W-1:0]  clk_reg;
    logic [31:0]       prod_reg;
    logic [15:0]       freq_reg;
    logic [NUM_CHANNELS-1:0] valid_reg;

    // output registers
    logic        m_valid_reg;
    logic [2:0]  o_index_reg;
    logic        o_wide_reg;
    logic [15:0] o_period_reg;
    logic [15:0] o_duty_reg;
    logic        o_written_reg;
    logic        o_port_reg;
    logic        o_hires_reg;
    logic [15:0] o_freq_reg;
    logic [15:0] o_ratio_reg;

    // handshakes and control
    logic in_accept;
    logic out_load;
    logic ram_re;
    logic ram_we;
    logic div_start;
    logic div_done;
    logic [DW-1:0] div_dividend;
    logic [15:0]   div_divisor;
    logic [DW-1:0] div_quot;

    // ram
    logic [ADDR_W-1:0]           idx;
    logic [ENTRY_W-1:0]          ram_rdata;
    pwmcalc_pkg::chan_entry_t    rd_entry;
    pwmcalc_pkg::chan_entry_t    wr_entry;

    // datapath helpers
    logic        en;
    logic        pol;
    logic        sel;
    logic        partner_en;
    logic        use_a;
    logic [2:0]  pre;
    logic [7:0]  scale_eff;
    logic [15:0] p_new;
    logic [15:0] p_use;
    logic [15:0] p_eff;
    logic [15:0] lim;
    logic        freq_direct;
    logic        freq_zero;
    logic [CW-1:0] q_ext;
    logic [15:0] period_clamped;
    logic [15:0] freq_clamped;
    logic [15:0] prod_hi;
    logic [15:0] prod_lo;
    logic [16:0] dsum;
    logic        round_up;
    logic        in_oob;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;
    assign idx       = ch_reg[ADDR_W-1:0];
    assign rd_entry  = pwmcalc_pkg::chan_entry_t'(ram_rdata);
    assign in_oob    = ({1'b0, s_axis_tdata[2:0]} >= 4'(NUM_CHANNELS));

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= pwmcalc_pkg::RST_ENABLE;
            polarity_reg   <= pwmcalc_pkg::RST_POLARITY;
            clksel_reg     <= pwmcalc_pkg::RST_CLKSEL;
            prescale_a_reg <= pwmcalc_pkg::RST_PRESCALE;
            prescale_b_reg <= pwmcalc_pkg::RST_PRESCALE;
            scale_a_reg    <= pwmcalc_pkg::RST_SCALE;
            scale_b_reg    <= pwmcalc_pkg::RST_SCALE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pwmcalc_pkg::cfg_reg_t'(cfg_index))
                pwmcalc_pkg::REG_ENABLE_MASK:   enable_reg     <= cfg_data;
                pwmcalc_pkg::REG_POLARITY_MASK: polarity_reg   <= cfg_data;
                pwmcalc_pkg::REG_CLKSEL_MASK:   clksel_reg     <= cfg_data;
                pwmcalc_pkg::REG_PRESCALE_A:    prescale_a_reg <= cfg_data[2:0];
                pwmcalc_pkg::REG_PRESCALE_B:    prescale_b_reg <= cfg_data[2:0];
                pwmcalc_pkg::REG_SCALE_A:       scale_a_reg    <= cfg_data;
                pwmcalc_pkg::REG_SCALE_B:       scale_b_reg    <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // per-channel bits, prescaler and limits
    always_comb
    begin
        en         = enable_reg[ch_reg];
        pol        = polarity_reg[ch_reg];
        sel        = clksel_reg[ch_reg];
        partner_en = enable_reg[{ch_reg[2:1], 1'b0}];
        use_a      = ~ch_reg[1];
        pre        = use_a ? prescale_a_reg : prescale_b_reg;
        scale_eff  = use_a ? scale_a_reg : scale_b_reg;
        if (scale_eff == 8'd0)
        begin
            scale_eff = 8'd1;
        end
        if (sel)
        begin
            p_new = 16'(scale_eff) << ({1'b0, pre} + 4'd1);
        end
        else
        begin
            p_new = 16'd1 << pre;
        end
        p_use = (cmd_reg == pwmcalc_pkg::CMD_INIT) ? p_new : pres_reg;
        p_eff = (p_use == 16'd0) ? 16'd1 : p_use;
        lim   = wide_reg ? pwmcalc_pkg::LIM_WIDE : pwmcalc_pkg::LIM_NARROW;
    end

    // frequency decisions and quotient clamps
    always_comb
    begin
        freq_direct    = !en || (CW'(val_reg) > CW'(clk_reg));
        freq_zero      = (val_reg == 16'd0);
        q_ext          = CW'(div_quot);
        period_clamped = (q_ext > CW'(lim)) ? lim : q_ext[15:0];
        freq_clamped   = (q_ext > CW'(pwmcalc_pkg::LIM_WIDE)) ? pwmcalc_pkg::LIM_WIDE
                                                               : q_ext[15:0];
    end

    // rounded divide by 65535 of ratio * period + half
    always_comb
    begin
        prod_hi  = prod_reg[31:16];
        prod_lo  = prod_reg[15:0];
        dsum     = {1'b0, prod_hi} + {1'b0, prod_lo};
        round_up = (dsum >= pwmcalc_pkg::DUTY_DIV);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pwmcalc_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = in_oob ? pwmcalc_pkg::S_OUT : pwmcalc_pkg::S_LOAD;
                end
            end
            pwmcalc_pkg::S_LOAD: state_next = pwmcalc_pkg::S_PRE;
            pwmcalc_pkg::S_PRE:  state_next = pwmcalc_pkg::S_CLK;
            pwmcalc_pkg::S_CLK:
            begin
                if (div_done)
                begin
                    unique case (cmd_reg) inside
                        pwmcalc_pkg::CMD_INIT,
                        pwmcalc_pkg::CMD_FREQ:  state_next = pwmcalc_pkg::S_FREQ;
                        pwmcalc_pkg::CMD_RATIO: state_next = pwmcalc_pkg::S_MUL;
                        default:                state_next = pwmcalc_pkg::S_QRY;
                    endcase
                end
            end
            pwmcalc_pkg::S_FREQ:
            begin
                if (freq_direct || freq_zero)
                begin
                    state_next = pwmcalc_pkg::S_MUL;
                end
                else
                begin
                    state_next = pwmcalc_pkg::S_FDIV;
                end
            end
            pwmcalc_pkg::S_FDIV:
            begin
                if (div_done)
                begin
                    state_next = pwmcalc_pkg::S_MUL;
                end
            end
            pwmcalc_pkg::S_MUL:  state_next = pwmcalc_pkg::S_DUTY;
            pwmcalc_pkg::S_DUTY: state_next = pwmcalc_pkg::S_QRY;
            pwmcalc_pkg::S_QRY:
            begin
                if (!en || period_reg == 16'd0)
                begin
                    state_next = pwmcalc_pkg::S_WB;
                end
                else
                begin
                    state_next = pwmcalc_pkg::S_QDIV;
                end
            end
            pwmcalc_pkg::S_QDIV:
            begin
                if (div_done)
                begin
                    state_next = pwmcalc_pkg::S_WB;
                end
            end
            pwmcalc_pkg::S_WB:   state_next = pwmcalc_pkg::S_OUT;
            pwmcalc_pkg::S_OUT:
            begin
                if (out_load)
                begin
                    state_next = pwmcalc_pkg::S_IDLE;
                end
            end
            default:             state_next = pwmcalc_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        div_start     = 1'b0;
        div_dividend  = DW'(clk_reg);
        div_divisor   = period_reg;
        out_load      = 1'b0;
        unique case (state_reg)
            pwmcalc_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                ram_re        = in_accept;
            end
            pwmcalc_pkg::S_PRE:
            begin
                div_start    = 1'b1;
                div_dividend = DW'(CLOCK_HZ);
                div_divisor  = p_eff;
            end
            pwmcalc_pkg::S_FREQ:
            begin
                div_start   = !(freq_direct || freq_zero);
                div_divisor = val_reg;
            end
            pwmcalc_pkg::S_QRY:
            begin
                div_start = en && (period_reg != 16'd0);
            end
            pwmcalc_pkg::S_WB:
            begin
                ram_we = 1'b1;
            end
            pwmcalc_pkg::S_OUT:
            begin
                out_load = !m_valid_reg || m_axis_tready;
            end
            default:
            begin
            end
        endcase
    end

    // state and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pwmcalc_pkg::S_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                valid_reg[idx] <= 1'b1;
            end
        end
    end

    // working registers, read-modify-write of one channel entry
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pwmcalc_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_reg <= pwmcalc_pkg::cmd_t'(s_axis_tuser);
                    ch_reg  <= s_axis_tdata[2:0];
                    val_reg <= s_axis_tdata[18:3];
                    oob_reg <= in_oob;
                end
            end
            pwmcalc_pkg::S_LOAD:
            begin
                if (valid_reg[idx])
                begin
                    pres_reg   <= rd_entry.prescaler;
                    period_reg <= rd_entry.period;
                    ratio_reg  <= rd_entry.ratio;
                    wide_reg   <= rd_entry.wide;
                    duty_reg   <= rd_entry.duty;
                end
                else
                begin
                    pres_reg   <= '0;
                    period_reg <= '0;
                    ratio_reg  <= '0;
                    wide_reg   <= 1'b0;
                    duty_reg   <= '0;
                end
            end
            pwmcalc_pkg::S_PRE:
            begin
                if (cmd_reg == pwmcalc_pkg::CMD_INIT)
                begin
                    pres_reg <= p_new;
                    wide_reg <= ch_reg[0] && !partner_en;
                end
            end
            pwmcalc_pkg::S_CLK:
            begin
                if (div_done)
                begin
                    clk_reg <= div_quot[CLK_W-1:0];
                    if (cmd_reg == pwmcalc_pkg::CMD_RATIO)
                    begin
                        ratio_reg <= val_reg;
                    end
                end
            end
            pwmcalc_pkg::S_FREQ:
            begin
                if (freq_direct)
                begin
                    period_reg <= 16'd1;
                end
                else if (freq_zero)
                begin
                    period_reg <= lim;
                end
            end
            pwmcalc_pkg::S_FDIV:
            begin
                if (div_done)
                begin
                    period_reg <= period_clamped;
                end
            end
            pwmcalc_pkg::S_MUL:
            begin
                prod_reg <= 32'(ratio_reg) * 32'(period_reg) + pwmcalc_pkg::DUTY_HALF;
            end
            pwmcalc_pkg::S_DUTY:
            begin
                duty_reg <= prod_hi + {15'd0, round_up};
            end
            pwmcalc_pkg::S_QRY:
            begin
                if (!en)
                begin
                    freq_reg <= 16'd0;
                end
                else if (period_reg == 16'd0)
                begin
                    freq_reg <= pwmcalc_pkg::LIM_WIDE;
                end
            end
            pwmcalc_pkg::S_QDIV:
            begin
                if (div_done)
                begin
                    freq_reg <= freq_clamped;
                end
            end
            default:
            begin
            end
        endcase
    end

    // write-back entry
    always_comb
    begin
        wr_entry.prescaler = pres_reg;
        wr_entry.period    = period_reg;
        wr_entry.ratio     = ratio_reg;
        wr_entry.wide      = wide_reg;
        wr_entry.duty      = duty_reg;
    end

    pwmcalc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (s_axis_tdata[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    pwmcalc_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_index_reg   <= '0;
            o_wide_reg    <= 1'b0;
            o_period_reg  <= '0;
            o_duty_reg    <= '0;
            o_written_reg <= 1'b0;
            o_port_reg    <= 1'b0;
            o_hires_reg   <= 1'b0;
            o_freq_reg    <= '0;
            o_ratio_reg   <= '0;
            if (!oob_reg)
            begin
                o_hires_reg <= wide_reg;
                o_freq_reg  <= freq_reg;
                o_ratio_reg <= ratio_reg;
                if (cmd_reg != pwmcalc_pkg::CMD_QUERY)
                begin
                    if (en)
                    begin
                        o_index_reg   <= wide_reg ? ch_reg - 3'd1 : ch_reg;
                        o_wide_reg    <= wide_reg;
                        o_period_reg  <= period_reg;
                        o_duty_reg    <= wide_reg ? duty_reg : {8'd0, duty_reg[7:0]};
                        o_written_reg <= 1'b1;
                    end
                    else
                    begin
                        o_port_reg <= (duty_reg != 16'd0) && pol;
                    end
                end
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'd0, o_ratio_reg, o_freq_reg, o_hires_reg, o_port_reg,
                            o_duty_reg, o_period_reg, o_index_reg};
    assign m_axis_tuser  = {o_written_reg, o_wide_reg};

endmodule

>>> design/pwmcalc_ram.sv
// ----------------------------------------------------------------------------
// pwmcalc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pwmcalc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/pwmcalc_div.sv
// ----------------------------------------------------------------------------
// pwmcalc_div
// Restoring unsigned divider, two quotient bits per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module pwmcalc_div #(
    parameter int DW = 26
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [15:0]   divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int STEPS = DW / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DW-1:0]     dd_reg;
    logic [15:0]       rem_reg;
    logic [15:0]       dsr_reg;

    logic [16:0]       r1;
    logic [16:0]       r2;
    logic              ge1;
    logic              ge2;
    logic [15:0]       rem1;
    logic [15:0]       rem2;
    logic [DW-1:0]     dd_next;

    // two restoring steps
    always_comb
    begin
        r1      = {rem_reg, dd_reg[DW-1]};
        ge1     = (r1 >= {1'b0, dsr_reg});
        rem1    = ge1 ? 16'(r1 - {1'b0, dsr_reg}) : r1[15:0];
        r2      = {rem1, dd_reg[DW-2]};
        ge2     = (r2 >= {1'b0, dsr_reg});
        rem2    = ge2 ? 16'(r2 - {1'b0, dsr_reg}) : r2[15:0];
        dd_next = {dd_reg[DW-3:0], ge1, ge2};
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dd_reg  <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dd_reg  <= dd_next;
            rem_reg <= rem2;
        end
    end

    assign done     = done_reg;
    assign quotient = dd_reg;

endmodule

>>> design/pwmcalc_chk.sv
// ----------------------------------------------------------------------------
// pwmcalc_chk
// Port-level checks of the PWM period and duty calculator, bound to the top.
// ----------------------------------------------------------------------------
module pwmcalc_chk (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [pwmcalc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [pwmcalc_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    // stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

    // an accepted command keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted back to back");

    // no register write means zero slot, period and duty
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |->
            (m_axis_tdata[34:0] == 35'd0) && !m_axis_tuser[0])
    else $error("write fields set without register write");

    // port level only for a channel that was not written
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tdata[35]))
    else $error("port level and register write together");

    // a wide write is only done in concatenated mode
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[36])
    else $error("wide write without concatenated mode");

endmodule

bind pwm_channel_period_duty_calculator_core pwmcalc_chk u_chk (.*);
